// File: rtl/core/text_console_tile_writer_top_macros.svh
// Assertion macros for the text console tile writer.
// Used by text_console_tile_writer_top.sv; expects clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_TILE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_TILE_WRITER_TOP_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tcw_pkg.sv
// Types, codes and constants of the text console tile writer.
// No dependencies; imported by text_console_tile_writer_top.
package tcw_pkg;

  localparam int MAP_CELLS = 1024;
  localparam int MAP_AW    = 10;
  localparam int GRID_CW   = 5;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_TILDE   = 8'd126;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_NUL     = 8'd0;

  typedef enum logic [2:0] {
    ACT_PUT     = 3'd0,
    ACT_CLEAR   = 3'd1,
    ACT_SUSPEND = 3'd2,
    ACT_RESTORE = 3'd3,
    ACT_READ    = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_REDRAW,
    ST_CHAR,
    ST_PAD,
    ST_RESP
  } st_e;

  function automatic logic [6:0] tile_of(input logic [7:0] ch);
    logic [7:0] diff;
    diff = ch - CHAR_SPACE;
    if (ch inside {[CHAR_SPACE:CHAR_TILDE]}) begin
      return diff[6:0];
    end
    return 7'd0;
  endfunction

endpackage

// File: rtl/core/text_console_tile_writer_top.sv
// Text console: character store and 32x32 glyph tile map in synchronous RAMs.
// Depends on tcw_pkg and text_console_tile_writer_top_macros.svh.
// Each accepted action yields one result; no new action is taken until that result is loaded.
// Newline pads with spaces to the end of the line; a focused clear also zeroes the tile map.
// Restore zeroes the map and redraws the text; a put into a full buffer scrolls first, and when
//   focused zeroes and redraws the map too. Reset: async, then map clear with in_ready_o low.
`include "text_console_tile_writer_top_macros.svh"

module text_console_tile_writer_top #(
  parameter int LINE_CHARS   = 30,
  parameter int BUFFER_CHARS = 600
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [7:0] char_code_i,
  input  logic [9:0] cell_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] cell_tile_o,
  output logic [9:0] cursor_o,
  output logic       scrolled_o,
  output logic       focused_o
);
  import tcw_pkg::*;

  localparam int PW   = $clog2(BUFFER_CHARS + 1);
  localparam int AW   = $clog2(BUFFER_CHARS);
  localparam int HALF = BUFFER_CHARS / 2;

  localparam logic [PW-1:0]      POS_FULL = PW'(BUFFER_CHARS);
  localparam logic [PW-1:0]      POS_LAST = PW'(BUFFER_CHARS - 1);
  localparam logic [PW-1:0]      POS_HALF = PW'(HALF);
  localparam logic [AW-1:0]      ADR_HALF = AW'(HALF);
  localparam logic [GRID_CW-1:0] COL_LAST = GRID_CW'(LINE_CHARS - 1);
  localparam logic [GRID_CW-1:0] HALF_COL = GRID_CW'(HALF % LINE_CHARS);
  localparam logic [GRID_CW-1:0] HALF_ROW = GRID_CW'((HALF / LINE_CHARS) % 32);
  localparam logic [MAP_AW-1:0]  CLR_LAST = MAP_AW'(MAP_CELLS - 1);

  logic [7:0] store_mem [BUFFER_CHARS];
  logic [6:0] map_mem   [MAP_CELLS];

  st_e                state_q, state_d;
  act_e               act_q, act_d;
  logic [7:0]         ch_q, ch_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [GRID_CW-1:0] row_q, row_d, col_q, col_d;
  logic               focus_q, focus_d;
  logic               scr_q, scr_d;
  logic [PW-1:0]      k_q, k_d;
  logic [MAP_AW-1:0]  clr_q, clr_d;
  logic [GRID_CW-1:0] dr_row_q, dr_row_d, dr_col_q, dr_col_d;
  logic               rd_v_q, rd_v_d;
  logic [MAP_AW-1:0]  cell_q, cell_d;
  logic [7:0]         store_rd_q;
  logic [6:0]         map_rd_q;

  logic               out_valid_q, out_valid_d;
  logic [6:0]         tile_out_q, tile_out_d;
  logic [9:0]         cur_out_q, cur_out_d;
  logic               scr_out_q, scr_out_d;
  logic               foc_out_q, foc_out_d;

  logic              store_we, store_re, map_we, map_re;
  logic [AW-1:0]     store_wa, store_ra;
  logic [7:0]        store_wd;
  logic [MAP_AW-1:0] map_wa, map_ra;
  logic [6:0]        map_wd;
  logic              accept, do_char, load_out;
  logic [7:0]        ch_cur;
  logic [PW-1:0]     k_dec;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign ch_cur     = (state_q == ST_IDLE) ? char_code_i : ch_q;
  assign k_dec      = k_q - PW'(1);

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    ch_d       = ch_q;
    pos_d      = pos_q;
    row_d      = row_q;
    col_d      = col_q;
    focus_d    = focus_q;
    scr_d      = scr_q;
    k_d        = k_q;
    clr_d      = clr_q;
    dr_row_d   = dr_row_q;
    dr_col_d   = dr_col_q;
    rd_v_d     = 1'b0;
    cell_d     = cell_q;
    store_we   = 1'b0;
    store_re   = 1'b0;
    store_wa   = pos_q[AW-1:0];
    store_ra   = k_q[AW-1:0];
    store_wd   = ch_cur;
    map_we     = 1'b0;
    map_re     = 1'b0;
    map_wa     = {row_q, col_q};
    map_ra     = cell_index_i;
    map_wd     = tile_of(ch_cur);
    do_char    = 1'b0;
    load_out   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d = act_e'(action_i);
          ch_d  = char_code_i;
          scr_d = 1'b0;
          case (act_e'(action_i))
            ACT_PUT: begin
              if (pos_q >= POS_FULL) begin
                scr_d   = 1'b1;
                k_d     = '0;
                state_d = ST_SCROLL;
              end else begin
                do_char = 1'b1;
              end
            end
            ACT_CLEAR: begin
              pos_d   = '0;
              row_d   = '0;
              col_d   = '0;
              clr_d   = '0;
              state_d = focus_q ? ST_CLEAR : ST_RESP;
            end
            ACT_SUSPEND: begin
              focus_d = 1'b0;
              state_d = ST_RESP;
            end
            ACT_RESTORE: begin
              focus_d = 1'b1;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            ACT_READ: begin
              map_re  = 1'b1;
              state_d = ST_RESP;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SCROLL: begin
        if (k_q < POS_HALF) begin
          store_re = 1'b1;
          store_ra = ADR_HALF + k_q[AW-1:0];
        end
        if (k_q != '0) begin
          store_we = 1'b1;
          store_wa = k_dec[AW-1:0];
          store_wd = store_rd_q;
        end
        k_d = k_q + PW'(1);
        if (k_q == POS_HALF) begin
          pos_d   = POS_HALF;
          row_d   = HALF_ROW;
          col_d   = HALF_COL;
          clr_d   = '0;
          state_d = focus_q ? ST_CLEAR : ST_CHAR;
        end
      end
      ST_INIT, ST_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_q;
        map_wd = '0;
        clr_d  = clr_q + MAP_AW'(1);
        if (clr_q == CLR_LAST) begin
          if (state_q == ST_INIT) begin
            state_d = ST_IDLE;
          end else if (act_q == ACT_CLEAR) begin
            state_d = ST_RESP;
          end else begin
            k_d      = '0;
            dr_row_d = '0;
            dr_col_d = '0;
            state_d  = ST_REDRAW;
          end
        end
      end
      ST_REDRAW: begin
        if (k_q < pos_q) begin
          store_re = 1'b1;
          store_ra = k_q[AW-1:0];
          rd_v_d   = 1'b1;
          cell_d   = {dr_row_q, dr_col_q};
          k_d      = k_q + PW'(1);
          if (dr_col_q == COL_LAST) begin
            dr_col_d = '0;
            dr_row_d = dr_row_q + GRID_CW'(1);
          end else begin
            dr_col_d = dr_col_q + GRID_CW'(1);
          end
        end
        if (rd_v_q) begin
          map_we = 1'b1;
          map_wa = cell_q;
          map_wd = tile_of(store_rd_q);
        end
        if (k_q >= pos_q && !rd_v_q) begin
          state_d = (act_q == ACT_PUT) ? ST_CHAR : ST_RESP;
        end
      end
      ST_CHAR: do_char = 1'b1;
      ST_PAD: begin
        store_we = 1'b1;
        store_wd = CHAR_SPACE;
        pos_d    = pos_q + PW'(1);
        if (col_q == COL_LAST) begin
          col_d = '0;
          row_d = row_q + GRID_CW'(1);
        end else begin
          col_d = col_q + GRID_CW'(1);
        end
        if (col_q == COL_LAST || pos_q == POS_LAST) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_char) begin
      if (ch_cur == CHAR_NUL) begin
        state_d = ST_RESP;
      end else if (ch_cur == CHAR_NEWLINE) begin
        state_d = ST_PAD;
      end else begin
        store_we = 1'b1;
        map_we   = focus_q;
        pos_d    = pos_q + PW'(1);
        if (col_q == COL_LAST) begin
          col_d = '0;
          row_d = row_q + GRID_CW'(1);
        end else begin
          col_d = col_q + GRID_CW'(1);
        end
        state_d = ST_RESP;
      end
    end

    tile_out_d  = (act_q == ACT_READ) ? map_rd_q : 7'd0;
    cur_out_d   = 10'(pos_q);
    scr_out_d   = scr_q;
    foc_out_d   = focus_q;
    out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      act_q       <= ACT_PUT;
      pos_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      focus_q     <= 1'b0;
      scr_q       <= 1'b0;
      k_q         <= '0;
      clr_q       <= '0;
      dr_row_q    <= '0;
      dr_col_q    <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
      focus_q     <= focus_d;
      scr_q       <= scr_d;
      k_q         <= k_d;
      clr_q       <= clr_d;
      dr_row_q    <= dr_row_d;
      dr_col_q    <= dr_col_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    cell_q <= cell_d;
    if (load_out) begin
      tile_out_q <= tile_out_d;
      cur_out_q  <= cur_out_d;
      scr_out_q  <= scr_out_d;
      foc_out_q  <= foc_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    if (store_re) begin
      store_rd_q <= store_mem[store_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_rd_q <= map_mem[map_ra];
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_tile_o = tile_out_q;
  assign cursor_o    = cur_out_q;
  assign scrolled_o  = scr_out_q;
  assign focused_o   = foc_out_q;

  `TCW_ASSERT_IMPL(a_pos_bound, 1'b1, pos_q <= POS_FULL, "cursor beyond buffer")
  `TCW_ASSERT_IMPL(a_map_we_focus, map_we && state_q != ST_INIT, focus_q, "map write unfocused")
  `TCW_ASSERT_NEXT(a_scroll_start, accept && action_i == ACT_PUT && pos_q >= POS_FULL,
                   state_q == ST_SCROLL && scr_q, "full buffer did not scroll")
  `TCW_ASSERT_IMPL(a_redraw_range, state_q == ST_REDRAW, k_q <= pos_q, "redraw past cursor")
  `TCW_ASSERT_IMPL(a_out_load, $rose(out_valid_q), $past(state_q) == ST_RESP, "result outside response")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for text_console_tile_writer_top: a shadow of the console's text
// store, cursor, tile map and focus predicts every reply. Random idling and a receiver hold-off.
// Depends on tcw_pkg and the RTL of text_console_tile_writer_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int LINE_CHARS   = 30;
  localparam int BUFFER_CHARS = 600;
  localparam int GRID_COLS    = 2 ** GRID_CW;
  localparam int TEXT_ROWS    = BUFFER_CHARS / LINE_CHARS;
  localparam int RANDOM_ITEMS = 1430;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  class console_mirror;
    typedef struct packed {
      logic [6:0] tile;
      logic [9:0] cursor;
      logic       scrolled;
      logic       focused;
    } reply_t;

    logic [7:0]  text_q[BUFFER_CHARS];
    logic [6:0]  tiles[MAP_CELLS];
    int unsigned wpos;
    bit          has_focus;
    reply_t      awaited_replies[$];
    int unsigned fault_count;

    function new();
      foreach (text_q[i]) text_q[i] = '0;
      foreach (tiles[i]) tiles[i] = '0;
      wpos = 0;
      has_focus = 1'b0;
      fault_count = 0;
    endfunction

    function void wipe_map();
      if (has_focus) foreach (tiles[i]) tiles[i] = '0;
    endfunction

    function void paint(int unsigned pos);
      int unsigned map_idx;
      logic [7:0]  ch;
      if (!has_focus || pos >= BUFFER_CHARS) return;
      map_idx = ((pos / LINE_CHARS) * GRID_COLS + pos % LINE_CHARS) % MAP_CELLS;
      ch = text_q[pos];
      tiles[map_idx] = (ch >= CHAR_SPACE && ch <= CHAR_TILDE) ? 7'(ch - CHAR_SPACE) : 7'd0;
    endfunction

    function void repaint();
      if (!has_focus) return;
      for (int unsigned k = 0; k < wpos && k < BUFFER_CHARS; k++) paint(k);
    endfunction

    function void note_action(logic [2:0] act, logic [7:0] ch, logic [9:0] cell_no);
      reply_t      r;
      int unsigned target;
      r = '0;
      case (act)
        ACT_PUT: begin
          if (wpos >= BUFFER_CHARS) begin
            // drop the first half, move the second half to the front
            for (int unsigned k = 0; k < BUFFER_CHARS / 2; k++) begin
              text_q[k] = text_q[k + BUFFER_CHARS / 2];
            end
            wpos = BUFFER_CHARS / 2;
            wipe_map();
            repaint();
            r.scrolled = 1'b1;
          end
          if (ch == CHAR_NEWLINE) begin
            target = (wpos / LINE_CHARS + 1) * LINE_CHARS;
            if (target > BUFFER_CHARS) target = BUFFER_CHARS;
            for (int unsigned k = wpos; k < target; k++) text_q[k] = CHAR_SPACE;
            if (target > wpos) wpos = target;
          end else if (ch != CHAR_NUL && wpos < BUFFER_CHARS) begin
            text_q[wpos] = ch;
            paint(wpos);
            wpos++;
          end
        end
        ACT_CLEAR: begin
          wpos = 0;
          wipe_map();
        end
        ACT_SUSPEND: has_focus = 1'b0;
        ACT_RESTORE: begin
          has_focus = 1'b1;
          wipe_map();
          repaint();
        end
        ACT_READ: r.tile = tiles[cell_no % MAP_CELLS];
        default: ;
      endcase
      r.cursor = wpos[9:0];
      r.focused = has_focus;
      awaited_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
          $display("unexpected reply: tile %0d cursor %0d scrolled %0b focused %0b",
                   got.tile, got.cursor, got.scrolled, got.focused);
        end
        return;
      end
      want = awaited_replies.pop_front();
      if (got !== want) begin
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
          $display("reply mismatch: expected tile %0d cursor %0d scrolled %0b focused %0b",
                   want.tile, want.cursor, want.scrolled, want.focused);
          $display("                got      tile %0d cursor %0d scrolled %0b focused %0b",
                   got.tile, got.cursor, got.scrolled, got.focused);
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [2:0] action_i     = ACT_PUT;
  logic [7:0] char_code_i  = '0;
  logic [9:0] cell_index_i = '0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [6:0] cell_tile_o;
  logic [9:0] cursor_o;
  logic       scrolled_o;
  logic       focused_o;

  logic          calm       = 1'b0;
  logic          hold_off   = 1'b0;
  int unsigned   items_sent = 0;
  console_mirror mirror     = new();

  text_console_tile_writer_top #(
    .LINE_CHARS  (LINE_CHARS),
    .BUFFER_CHARS(BUFFER_CHARS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_tile_o (cell_tile_o),
    .cursor_o    (cursor_o),
    .scrolled_o  (scrolled_o),
    .focused_o   (focused_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && (calm || $urandom_range(0, 99) >= 14);
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (items_sent >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mirror.check_reply({cell_tile_o, cursor_o, scrolled_o, focused_o});
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_action(act_e act, logic [7:0] ch, logic [9:0] cell_no);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    char_code_i  <= ch;
    cell_index_i <= cell_no;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.note_action(act, ch, cell_no);
    items_sent++;
  endtask

  initial begin
    int unsigned pick;
    act_e        act;
    logic [7:0]  ch;
    logic [9:0]  cell_no;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_action(ACT_READ, CHAR_NUL, '0);
    send_action(ACT_PUT, "A", '0);
    send_action(ACT_RESTORE, CHAR_NUL, '0);
    send_action(ACT_READ, CHAR_NUL, '0);
    send_action(ACT_PUT, CHAR_NUL, '1);
    send_action(ACT_PUT, CHAR_TILDE, '0);
    send_action(ACT_PUT, CHAR_SPACE, '0);
    send_action(ACT_PUT, 8'h7f, '0);
    send_action(ACT_PUT, 8'hff, '0);
    send_action(ACT_PUT, 8'h1f, '0);
    send_action(ACT_PUT, CHAR_NEWLINE, '0);
    send_action(ACT_PUT, "z", '0);
    send_action(ACT_READ, CHAR_NUL, 10'd1);
    send_action(ACT_READ, CHAR_NUL, 10'(GRID_COLS));
    send_action(ACT_READ, 8'hff, '1);
    send_action(ACT_SUSPEND, CHAR_NUL, '0);
    send_action(ACT_PUT, "B", '0);
    send_action(ACT_READ, CHAR_NUL, 10'(GRID_COLS + 1));
    send_action(ACT_CLEAR, CHAR_NUL, '0);
    send_action(ACT_READ, CHAR_NUL, 10'(GRID_COLS));
    send_action(ACT_RESTORE, CHAR_NUL, '0);
    send_action(ACT_READ, CHAR_NUL, 10'(GRID_COLS));
    send_action(ACT_PUT, CHAR_NEWLINE, '0);
    send_action(ACT_PUT, 8'h80, '0);
    send_action(ACT_CLEAR, CHAR_NUL, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 700 && n < 900);
      ch = 8'($urandom);
      cell_no = 10'($urandom);
      pick = $urandom_range(0, 999);
      if (pick < 830) begin
        act = ACT_PUT;
        pick = $urandom_range(0, 99);
        if (pick < 12) ch = CHAR_NEWLINE;
        else if (pick < 15) ch = CHAR_NUL;
        else if (pick < 85) ch = 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
      end else if (pick < 930) begin
        act = ACT_READ;
        if ($urandom_range(0, 1) == 1) begin
          cell_no = 10'($urandom_range(0, TEXT_ROWS - 1) * GRID_COLS
                        + $urandom_range(0, LINE_CHARS - 1));
        end
      end else if (pick < 952) begin
        act = ACT_SUSPEND;
      end else if (pick < 977) begin
        act = ACT_RESTORE;
      end else if (pick < 981) begin
        act = ACT_CLEAR;
      end else begin
        act = ACT_PUT;
        ch = CHAR_NEWLINE;
      end
      send_action(act, ch, cell_no);
    end
    in_valid_i <= 1'b0;

    while (mirror.awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.fault_count == 0 && mirror.awaited_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
